>>> src/knn_euclidean_search_unit_macros.svh
// Assertion macros for the nearest-neighbor search unit.
`ifndef KNN_EUCLIDEAN_SEARCH_UNIT_MACROS_SVH
`define KNN_EUCLIDEAN_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define KSU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KSU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ksu_pkg.sv
// Package: shared constants, codes and types of the search unit.
package ksu_pkg;

  localparam int DEF_MAX_VECTORS   = 256;
  localparam int DEF_MAX_LENGTH    = 64;
  localparam int DEF_MAX_NEIGHBORS = 16;

  localparam int ELEM_W = 16;
  localparam int DSQ_W  = 38;
  localparam int DIST_W = 19;
  localparam int SLOT_W = 8;
  localparam int CFG_W  = 9;
  localparam int CIDX_W = 2;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_VECTOR_LENGTH    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_STORE_LIMIT      = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_NEIGHBORS_WANTED = 2'd2;

  typedef enum logic [2:0] {
    OC_STORED   = 3'd0,
    OC_REJECTED = 3'd1,
    OC_NEIGHBOR = 3'd2,
    OC_EMPTY    = 3'd3,
    OC_CLEARED  = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SQRT,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic flush;
    logic shift;
  } cell_ctrl_t;

endpackage

>>> src/ksu_if.sv
// Handshake interfaces for input items and result items.
interface ksu_req_if import ksu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [ELEM_W-1:0] element;
  logic                     final_element;

  modport source (output valid, kind, element, final_element, input ready);
  modport sink   (input valid, kind, element, final_element, output ready);
endinterface

interface ksu_rsp_if import ksu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        outcome;
  logic [SLOT_W-1:0] slot;
  logic [DSQ_W-1:0]  distance_squared;
  logic [DIST_W-1:0] distance;
  logic              last_result;

  modport source (output valid, outcome, slot, distance_squared, distance, last_result,
                  input ready);
  modport sink   (input valid, outcome, slot, distance_squared, distance, last_result,
                  output ready);
endinterface

>>> src/ksu_cell.sv
// Sorting cell: holds one ranked candidate, passes the loser to its neighbor.
module ksu_cell import ksu_pkg::*; #(
  parameter int SUM_W   = 39,
  parameter int SLOT_IW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic               en,
  input  logic               in_v,
  input  logic [SUM_W-1:0]   in_d,
  input  logic [SLOT_IW-1:0] in_s,
  input  logic               next_v,
  input  logic [SUM_W-1:0]   next_d,
  input  logic [SLOT_IW-1:0] next_s,
  output logic               pass_v,
  output logic [SUM_W-1:0]   pass_d,
  output logic [SLOT_IW-1:0] pass_s,
  output logic               held_v,
  output logic [SUM_W-1:0]   held_d,
  output logic [SLOT_IW-1:0] held_s
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      held_v <= 1'b0;
      pass_v <= 1'b0;
    end else if (ctrl.shift) begin
      held_v <= next_v;
      held_d <= next_d;
      held_s <= next_s;
      pass_v <= 1'b0;
    end else if (in_v && en) begin
      if (!held_v) begin
        held_v <= 1'b1;
        held_d <= in_d;
        held_s <= in_s;
        pass_v <= 1'b0;
      end else if (in_d < held_d || (in_d == held_d && in_s < held_s)) begin
        // equal distances rank by slot
        held_d <= in_d;
        held_s <= in_s;
        pass_v <= 1'b1;
        pass_d <= held_d;
        pass_s <= held_s;
      end else begin
        pass_v <= 1'b1;
        pass_d <= in_d;
        pass_s <= in_s;
      end
    end else begin
      pass_v <= 1'b0;
    end
  end

endmodule

>>> src/ksu_isqrt.sv
// Floor square root, two radicand bits per cycle.
module ksu_isqrt import ksu_pkg::*; #(
  parameter int IN_W = 39
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IN_W-1:0]   value,
  output logic              busy,
  output logic [(IN_W+1)/2-1:0] root
);

  localparam int RW    = (IN_W + 1) / 2;
  localparam int STP_W = $clog2(RW + 1);

  logic [2*RW-1:0]  x;
  logic [RW+1:0]    rem;
  logic [STP_W-1:0] steps;
  logic [RW+2:0]    rem2;
  logic [RW+2:0]    trial;
  logic [RW+2:0]    diff;

  assign rem2  = {rem[RW:0], x[2*RW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = rem2 - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      x     <= (2*RW)'(value);
      rem   <= '0;
      root  <= '0;
      steps <= STP_W'(RW);
    end else if (busy) begin
      x <= {x[2*RW-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem  <= diff[RW+1:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem2[RW+1:0];
        root <= {root[RW-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
      if (steps == STP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> src/knn_euclidean_search_unit.sv
// Top level: vector store, distance scan, sorting chain and result output.
//
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  kind, element, final_element
//  rsp      out  rsp.valid/rsp.ready  outcome, slot, distance_squared, distance, last_result
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// Element items are accepted while the unit is idle and the result register is free;
// the result of a store, clear or rejected item is registered in the cycle after it is taken.
// A query's final element starts a scan of every stored vector through the single
// vector memory read port, then a drain state that settles the sorting chain, then
// one root unit computation per neighbor. Reset is synchronous; memories are not cleared.
// rsp.ready low while a result is valid holds the result register and blocks further input.
`include "knn_euclidean_search_unit_macros.svh"

module knn_euclidean_search_unit import ksu_pkg::*; #(
  parameter int MAX_VECTORS   = DEF_MAX_VECTORS,
  parameter int MAX_LENGTH    = DEF_MAX_LENGTH,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
  input  logic              clk,
  input  logic              rst,
  ksu_req_if.sink           req,
  ksu_rsp_if.source         rsp,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int SLOT_IW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int CNT_W   = $clog2(MAX_VECTORS + 1);
  localparam int IDX_W   = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int ECNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int DEPTH   = MAX_VECTORS * MAX_LENGTH;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W   = 32 + ECNT_W;
  localparam int K_W     = $clog2(MAX_NEIGHBORS + 1);
  localparam int DRAIN_N = MAX_NEIGHBORS + 4;
  localparam int DRN_W   = $clog2(DRAIN_N + 1);
  localparam int RW      = (SUM_W + 1) / 2;

  logic [6:0] vector_length;
  logic [8:0] store_limit;
  logic [4:0] neighbors_wanted;

  logic [CNT_W-1:0]  stored_count;
  logic [ECNT_W-1:0] element_counter;
  logic              length_overrun;

  logic [ELEM_W-1:0] vmem [DEPTH];
  logic [ELEM_W-1:0] qmem [MAX_LENGTH];
  logic [ELEM_W-1:0] vrd;
  logic [ELEM_W-1:0] qrd;

  state_t state, state_next;

  logic               rsp_v;
  outcome_t           rsp_oc;
  logic [SLOT_W-1:0]  rsp_slot;
  logic [DSQ_W-1:0]   rsp_dsq;
  logic [DIST_W-1:0]  rsp_dist;
  logic               rsp_last;
  logic               rsp_load;

  logic              req_fire;
  logic              rsp_free;
  logic              room;
  logic [ECNT_W-1:0] ecnt_after;
  logic              length_ok;
  logic              query_go;
  int                lim;
  int                k_eff;

  logic [SLOT_IW-1:0] sc_slot;
  logic [IDX_W-1:0]   sc_elem;
  logic               sc_last_elem;
  logic               sc_last_slot;
  logic [DRN_W-1:0]   drain_cnt;
  logic [K_W-1:0]     remaining;

  logic               s1_v, s1_first, s1_last;
  logic [SLOT_IW-1:0] s1_slot;
  logic               s2_v, s2_first, s2_last;
  logic [SLOT_IW-1:0] s2_slot;
  logic [31:0]        prod;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   acc_sum;
  logic signed [16:0] diff;
  logic signed [33:0] sq;

  logic               cand_v;
  logic [SUM_W-1:0]   cand_d;
  logic [SLOT_IW-1:0] cand_s;

  cell_ctrl_t ctrl;
  logic               sq_start;
  logic               sq_busy;
  logic [RW-1:0]      sq_root;

  logic               c_pass_v [MAX_NEIGHBORS];
  logic [SUM_W-1:0]   c_pass_d [MAX_NEIGHBORS];
  logic [SLOT_IW-1:0] c_pass_s [MAX_NEIGHBORS];
  logic               c_held_v [MAX_NEIGHBORS];
  logic [SUM_W-1:0]   c_held_d [MAX_NEIGHBORS];
  logic [SLOT_IW-1:0] c_held_s [MAX_NEIGHBORS];

  assign rsp_free  = !rsp_v || rsp.ready;
  assign req.ready = (state == ST_IDLE) && rsp_free;
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid            = rsp_v;
  assign rsp.outcome          = rsp_oc;
  assign rsp.slot             = rsp_slot;
  assign rsp.distance_squared = rsp_dsq;
  assign rsp.distance         = rsp_dist;
  assign rsp.last_result      = rsp_last;

  assign room       = int'(element_counter) < MAX_LENGTH;
  assign ecnt_after = room ? element_counter + 1'b1 : element_counter;
  assign length_ok  = !length_overrun && room && (int'(ecnt_after) == int'(vector_length));
  assign lim        = (int'(store_limit) > MAX_VECTORS) ? MAX_VECTORS : int'(store_limit);
  assign k_eff      = (int'(neighbors_wanted) > MAX_NEIGHBORS) ? MAX_NEIGHBORS
                                                               : int'(neighbors_wanted);
  assign query_go   = req_fire && req.kind == KIND_QUERY && req.final_element && length_ok
                      && stored_count != '0 && neighbors_wanted != '0;
  assign rsp_load   = (req_fire && (req.kind == KIND_CLEAR
                       || ((req.kind == KIND_STORE || req.kind == KIND_QUERY)
                           && req.final_element && !query_go)))
                      || (state == ST_OUT && rsp_free);

  assign sc_last_elem = int'(sc_elem) == int'(vector_length) - 1;
  assign sc_last_slot = int'(sc_slot) == int'(stored_count) - 1;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length    <= 7'd64;
      store_limit      <= 9'd256;
      neighbors_wanted <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VECTOR_LENGTH:    vector_length    <= cfg_data[6:0];
        CFG_STORE_LIMIT:      store_limit      <= cfg_data;
        CFG_NEIGHBORS_WANTED: neighbors_wanted <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (req_fire && req.kind == KIND_STORE && room && int'(stored_count) < MAX_VECTORS) begin
      vmem[ADDR_W'(int'(stored_count) * MAX_LENGTH + int'(element_counter))] <= req.element;
    end
    if (req_fire && req.kind == KIND_QUERY && room) begin
      qmem[element_counter[IDX_W-1:0]] <= req.element;
    end
    vrd <= vmem[ADDR_W'(int'(sc_slot) * MAX_LENGTH + int'(sc_elem))];
    qrd <= qmem[sc_elem];
  end

  // Store bookkeeping, single-result outcomes and neighbor results.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      element_counter <= '0;
      length_overrun  <= 1'b0;
      rsp_v           <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_v <= 1'b1;
      end else if (rsp.ready) begin
        rsp_v <= 1'b0;
      end
      if (req_fire && req.kind == KIND_CLEAR) begin
        stored_count    <= '0;
        element_counter <= '0;
        length_overrun  <= 1'b0;
        rsp_oc   <= OC_CLEARED;
        rsp_slot <= '0;
        rsp_dsq  <= '0;
        rsp_dist <= '0;
        rsp_last <= 1'b1;
      end else if (req_fire && (req.kind == KIND_STORE || req.kind == KIND_QUERY)) begin
        if (req.final_element) begin
          element_counter <= '0;
          length_overrun  <= 1'b0;
          if (req.kind == KIND_STORE) begin
            rsp_dsq  <= '0;
            rsp_dist <= '0;
            rsp_last <= 1'b1;
            if (length_ok && int'(stored_count) < lim) begin
              rsp_oc       <= OC_STORED;
              rsp_slot     <= SLOT_W'(stored_count);
              stored_count <= stored_count + 1'b1;
            end else begin
              rsp_oc   <= OC_REJECTED;
              rsp_slot <= '0;
            end
          end else if (!query_go) begin
            rsp_oc   <= OC_EMPTY;
            rsp_slot <= '0;
            rsp_dsq  <= '0;
            rsp_dist <= '0;
            rsp_last <= 1'b1;
          end
        end else begin
          element_counter <= ecnt_after;
          if (!room) begin
            length_overrun <= 1'b1;
          end
        end
      end else if (state == ST_OUT && rsp_free) begin
        rsp_oc   <= OC_NEIGHBOR;
        rsp_slot <= SLOT_W'(c_held_s[0]);
        rsp_dsq  <= DSQ_W'(c_held_d[0]);
        rsp_dist <= DIST_W'(sq_root);
        rsp_last <= remaining == K_W'(1);
      end
    end
  end

  // Scan, drain and remaining-neighbor counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_cnt <= '0;
      remaining <= '0;
    end else begin
      if (query_go) begin
        sc_slot   <= '0;
        sc_elem   <= '0;
        remaining <= (int'(stored_count) < k_eff) ? K_W'(stored_count) : K_W'(k_eff);
      end else if (state == ST_SCAN) begin
        if (sc_last_elem) begin
          sc_elem <= '0;
          sc_slot <= sc_slot + 1'b1;
        end else begin
          sc_elem <= sc_elem + 1'b1;
        end
      end
      if (state == ST_SCAN) begin
        drain_cnt <= '0;
      end else if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + 1'b1;
      end
      if (state == ST_OUT && rsp_free) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  // Distance pipeline: read, square, accumulate.
  assign diff    = $signed({qrd[ELEM_W-1], qrd}) - $signed({vrd[ELEM_W-1], vrd});
  assign sq      = diff * diff;
  assign acc_sum = (s2_first ? '0 : acc) + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      cand_v <= 1'b0;
    end else begin
      s1_v     <= state == ST_SCAN;
      s1_first <= sc_elem == '0;
      s1_last  <= sc_last_elem;
      s1_slot  <= sc_slot;
      s2_v     <= s1_v;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_slot  <= s1_slot;
      prod     <= sq[31:0];
      cand_v   <= s2_v && s2_last;
      if (s2_v) begin
        acc <= acc_sum;
        if (s2_last) begin
          cand_d <= acc_sum;
          cand_s <= s2_slot;
        end
      end
    end
  end

  // Sorting chain.
  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    logic               in_v;
    logic [SUM_W-1:0]   in_d;
    logic [SLOT_IW-1:0] in_s;
    logic               nx_v;
    logic [SUM_W-1:0]   nx_d;
    logic [SLOT_IW-1:0] nx_s;
    if (i == 0) begin : g_head
      assign in_v = cand_v;
      assign in_d = cand_d;
      assign in_s = cand_s;
    end else begin : g_body
      assign in_v = c_pass_v[i-1];
      assign in_d = c_pass_d[i-1];
      assign in_s = c_pass_s[i-1];
    end
    if (i == MAX_NEIGHBORS - 1) begin : g_tail
      assign nx_v = 1'b0;
      assign nx_d = '0;
      assign nx_s = '0;
    end else begin : g_mid
      assign nx_v = c_held_v[i+1];
      assign nx_d = c_held_d[i+1];
      assign nx_s = c_held_s[i+1];
    end
    ksu_cell #(.SUM_W(SUM_W), .SLOT_IW(SLOT_IW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .en     (i < k_eff),
      .in_v   (in_v),
      .in_d   (in_d),
      .in_s   (in_s),
      .next_v (nx_v),
      .next_d (nx_d),
      .next_s (nx_s),
      .pass_v (c_pass_v[i]),
      .pass_d (c_pass_d[i]),
      .pass_s (c_pass_s[i]),
      .held_v (c_held_v[i]),
      .held_d (c_held_d[i]),
      .held_s (c_held_s[i])
    );
  end

  ksu_isqrt #(.IN_W(SUM_W)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (c_held_d[0]),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    sq_start   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (query_go) begin
          ctrl.flush = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sc_last_elem && sc_last_slot) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == DRN_W'(DRAIN_N)) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sq_start   = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sq_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (rsp_free) begin
          ctrl.shift = 1'b1;
          state_next = (remaining == K_W'(1)) ? ST_IDLE : ST_SQRT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `KSU_ASSERT_IMP(a_count_bound, clk, rst, 1'b1,
                  int'(stored_count) <= MAX_VECTORS, "stored count above capacity")
  `KSU_ASSERT_IMP(a_remaining, clk, rst, state == ST_SQRT || state == ST_OUT,
                  remaining != '0, "no neighbor left to report")
  `KSU_ASSERT_IMP(a_head_valid, clk, rst, state == ST_OUT,
                  c_held_v[0] && !sq_busy, "reporting an empty chain head")
  `KSU_ASSERT_NXT(a_flush, clk, rst, query_go,
                  !c_held_v[0] && state == ST_SCAN, "chain not flushed at query start")

endmodule

>>> sim/knn_euclidean_search_unit_tb.sv
// Testbench for knn_euclidean_search_unit: directed and random traffic checked against a predictor.
module knn_euclidean_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ksu_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NVEC = DEF_MAX_VECTORS;
  localparam int NLEN = DEF_MAX_LENGTH;
  localparam int NNBR = DEF_MAX_NEIGHBORS;

  typedef struct packed {
    outcome_t           outcome;
    logic [SLOT_W-1:0]  slot;
    logic [DSQ_W-1:0]   dsq;
    logic [DIST_W-1:0]  droot;
    logic               last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  ksu_req_if req();
  ksu_rsp_if rsp();

  knn_euclidean_search_unit uut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [ELEM_W-1:0] vec_mem [NVEC][NLEN];
  logic [ELEM_W-1:0] query_vec [NLEN];
  int unsigned n_stored = 0;
  int unsigned n_elems = 0;
  bit overrun = 0;
  int unsigned vec_len = 64;
  int unsigned vec_limit = 256;
  int unsigned k_wanted = 1;

  result_t expected_results[$];
  int mismatches = 0;
  bit quiet = 0;
  int random_items = 0;

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void expect_result(input outcome_t oc, input int unsigned slot,
                                        input longint unsigned dsq, input int last);
    result_t r;
    r.outcome = oc;
    r.slot = slot[SLOT_W-1:0];
    r.dsq = dsq[DSQ_W-1:0];
    r.droot = DIST_W'(floor_sqrt(dsq));
    r.last = (last != 0);
    expected_results = {expected_results, r};
  endfunction

  function automatic void predict_neighbors();
    longint unsigned best_d [NNBR];
    int unsigned best_s [NNBR];
    longint unsigned d;
    longint signed a, b, df;
    int unsigned k, filled, pos, i;
    k = (k_wanted > NNBR) ? NNBR : k_wanted;
    filled = 0;
    for (int unsigned s = 0; s < n_stored; s++) begin
      d = 0;
      for (i = 0; i < vec_len; i++) begin
        a = $signed(query_vec[i]);
        b = $signed(vec_mem[s][i]);
        df = a - b;
        d += df * df;
      end
      pos = filled;
      while (pos > 0 && d < best_d[pos-1]) pos--;
      if (pos < k) begin
        if (filled < k) filled++;
        for (i = filled - 1; i > pos; i--) begin
          best_d[i] = best_d[i-1];
          best_s[i] = best_s[i-1];
        end
        best_d[pos] = d;
        best_s[pos] = s;
      end
    end
    for (i = 0; i < filled; i++)
      expect_result(OC_NEIGHBOR, best_s[i], best_d[i], i + 1 == filled);
  endfunction

  function automatic void predict_item(input logic [1:0] kind, input logic [ELEM_W-1:0] e,
                                       input logic fin);
    bit len_ok;
    int unsigned lim;
    if (kind == KIND_UNUSED) return;
    if (kind == KIND_CLEAR) begin
      n_stored = 0;
      n_elems = 0;
      overrun = 0;
      expect_result(OC_CLEARED, 0, 0, 1);
      return;
    end
    if (n_elems < NLEN) begin
      if (kind == KIND_STORE) begin
        if (n_stored < NVEC) vec_mem[n_stored][n_elems] = e;
      end else begin
        query_vec[n_elems] = e;
      end
      n_elems++;
    end else begin
      overrun = 1;
    end
    if (!fin) return;
    len_ok = !overrun && n_elems == vec_len;
    n_elems = 0;
    overrun = 0;
    if (kind == KIND_STORE) begin
      lim = (vec_limit > NVEC) ? NVEC : vec_limit;
      if (len_ok && n_stored < lim) begin
        expect_result(OC_STORED, n_stored, 0, 1);
        n_stored++;
      end else begin
        expect_result(OC_REJECTED, 0, 0, 1);
      end
    end else if (!len_ok || n_stored == 0 || k_wanted == 0) begin
      expect_result(OC_EMPTY, 0, 0, 1);
    end else begin
      predict_neighbors();
    end
  endfunction

  // check results first, then predict the transaction accepted at the same edge
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.outcome = outcome_t'(rsp.outcome);
        got.slot = rsp.slot;
        got.dsq = rsp.distance_squared;
        got.droot = rsp.distance;
        got.last = rsp.last_result;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: outcome %0d slot %0d dsq %0d dist %0d last %0d",
                     rsp.outcome, got.slot, got.dsq, got.droot, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch: exp oc %0d slot %0d dsq %0d dist %0d last %0d",
                     want.outcome, want.slot, want.dsq, want.droot, want.last);
              $display(" / got oc %0d slot %0d dsq %0d dist %0d last %0d",
                       rsp.outcome, got.slot, got.dsq, got.droot, got.last);
            end
          end
        end
      end
      if (req.valid && req.ready)
        predict_item(req.kind, req.element, req.final_element);
      if (cfg_we) begin
        case (cfg_index)
          CFG_VECTOR_LENGTH:    vec_len = cfg_data[6:0];
          CFG_STORE_LIMIT:      vec_limit = cfg_data[8:0];
          CFG_NEIGHBORS_WANTED: k_wanted = cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  // result-side backpressure
  always begin
    @(negedge clk);
    if (quiet || $urandom_range(2) != 0) begin
      rsp.ready = 1'b1;
    end else begin
      rsp.ready = 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [ELEM_W-1:0] e,
                           input logic fin);
    @(negedge clk);
    if (!quiet && $urandom_range(5) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    req.valid = 1'b1;
    req.kind = kind;
    req.element = e;
    req.final_element = fin;
    do @(posedge clk); while (!req.ready);
    if (kind != KIND_UNUSED) random_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned value);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic send_vector(input logic [1:0] kind, input int unsigned n,
                             input logic [1:0] last_kind, input int fixed,
                             input int unsigned fill);
    for (int unsigned i = 0; i < n; i++)
      send_item(i == n - 1 ? last_kind : kind,
                (fixed != 0) ? ELEM_W'(fill) : pick_element(), i == n - 1);
  endtask

  task automatic test_full_length();
    // empty-store query also fills the whole query buffer
    send_vector(KIND_QUERY, 64, KIND_QUERY, 1, 16'h7fff);
    send_vector(KIND_STORE, 64, KIND_STORE, 1, 16'h8000);
    send_vector(KIND_QUERY, 64, KIND_QUERY, 1, 16'h7fff);
    send_vector(KIND_STORE, 66, KIND_STORE, 0, 0);
    send_item(KIND_CLEAR, ELEM_W'($urandom), 1'b0);
  endtask

  task automatic test_register_edges();
    write_reg(CFG_VECTOR_LENGTH, 0);
    send_vector(KIND_STORE, 1, KIND_STORE, 0, 0);
    write_reg(CFG_VECTOR_LENGTH, 127);
    send_vector(KIND_STORE, 2, KIND_STORE, 0, 0);
    write_reg(CFG_VECTOR_LENGTH, 2);
    write_reg(CFG_STORE_LIMIT, 0);
    send_vector(KIND_STORE, 2, KIND_STORE, 0, 0);
    write_reg(CFG_STORE_LIMIT, 1);
    send_vector(KIND_STORE, 2, KIND_STORE, 0, 0);
    send_vector(KIND_STORE, 2, KIND_STORE, 0, 0);
    write_reg(CFG_STORE_LIMIT, 511);
    send_vector(KIND_STORE, 2, KIND_STORE, 0, 0);
    send_vector(KIND_STORE, 2, KIND_STORE, 0, 0);
    write_reg(CFG_NEIGHBORS_WANTED, 0);
    send_vector(KIND_QUERY, 2, KIND_QUERY, 0, 0);
    write_reg(CFG_NEIGHBORS_WANTED, 31);
    send_vector(KIND_QUERY, 2, KIND_QUERY, 0, 0);
    send_vector(KIND_STORE, 2, KIND_QUERY, 0, 0);
    send_vector(KIND_QUERY, 3, KIND_QUERY, 0, 0);
    send_item(KIND_UNUSED, ELEM_W'($urandom), 1'b1);
    send_item(KIND_CLEAR, ELEM_W'($urandom), 1'b1);
    send_vector(KIND_QUERY, 2, KIND_QUERY, 0, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned len, op, steps, phase;
    phase = 0;
    random_items = 0;
    while (random_items < 110) begin
      wait_idle();
      send_item(KIND_CLEAR, ELEM_W'($urandom), 1'($urandom));
      len = $urandom_range(1, 6);
      write_reg(CFG_VECTOR_LENGTH, len);
      write_reg(CFG_STORE_LIMIT, $urandom_range(3) == 0 ? 256 : $urandom_range(1, 12));
      write_reg(CFG_NEIGHBORS_WANTED,
                $urandom_range(5) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16));
      steps = $urandom_range(8, 16);
      for (int s = 0; s < steps; s++) begin
        if (phase == 1 && s == steps / 2) wait_idle();
        op = $urandom_range(99);
        if (op < 50) send_vector(KIND_STORE, len, KIND_STORE, 0, 0);
        else if (op < 75) send_vector(KIND_QUERY, len, KIND_QUERY, 0, 0);
        else if (op < 85)
          send_vector($urandom_range(1) ? KIND_STORE : KIND_QUERY,
                      $urandom_range(1) ? len + $urandom_range(1, 2)
                                        : (len > 1 ? $urandom_range(1, len - 1) : len + 1),
                      $urandom_range(1) ? KIND_STORE : KIND_QUERY, 0, 0);
        else if (op < 92) send_vector($urandom_range(1) ? KIND_STORE : KIND_QUERY, len,
                                      KIND_QUERY, 0, 0);
        else if (op < 96) send_item(KIND_UNUSED, ELEM_W'($urandom), 1'($urandom));
        else send_item(KIND_CLEAR, ELEM_W'($urandom), 1'($urandom));
      end
      phase++;
    end
  endtask

  task automatic test_store_full();
    quiet = 1;
    wait_idle();
    send_item(KIND_CLEAR, ELEM_W'($urandom), 1'b1);
    write_reg(CFG_VECTOR_LENGTH, 1);
    write_reg(CFG_STORE_LIMIT, 256);
    write_reg(CFG_NEIGHBORS_WANTED, 16);
    for (int i = 0; i < 257; i++) send_item(KIND_STORE, pick_element(), 1'b1);
    send_vector(KIND_QUERY, 1, KIND_QUERY, 0, 0);
    send_vector(KIND_QUERY, 1, KIND_QUERY, 1, 16'h0000);
  endtask

  initial begin
    req.valid = 1'b0;
    req.kind = KIND_STORE;
    req.element = '0;
    req.final_element = 1'b0;
    rsp.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_full_length();
    test_register_edges();
    test_random_traffic();
    test_store_full();
    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("knn_euclidean_search_unit_tb passed");
    end else begin
      $display("knn_euclidean_search_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("knn_euclidean_search_unit_tb failed");
    $finish;
  end
endmodule
